// ===== hdl/pwmm_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM meter package
// Shared widths, reset values, register indexes, divider operations and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pwmm_pkg;

  localparam int DEF_COUNT_WIDTH = 24;
  localparam int DEF_MS_WIDTH    = 20;

  localparam int PRESCALE_W  = 11;
  localparam int CLOCK_KHZ_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 1;

  localparam int HIGH_MS_W = 20;
  localparam int LOW_MS_W  = 20;
  localparam int DUTY_W    = 7;
  localparam int FREQ_W    = 8;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 1;

  localparam logic [PRESCALE_W-1:0]  PRESCALE_RST  = PRESCALE_W'(1024);
  localparam logic [CLOCK_KHZ_W-1:0] CLOCK_KHZ_RST = CLOCK_KHZ_W'(16000);

  localparam logic [CFG_ADDR_W-1:0] CFG_PRESCALE  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_CLOCK_KHZ = CFG_ADDR_W'(1);

  // Duty is at most 100, so its quotient fits in seven bits.
  localparam int DUTY_SCALE  = 100;
  localparam int DUTY_STEPS  = 7;
  localparam int FREQ_NUM    = 1000;
  localparam int FREQ_STEPS  = 10;
  localparam int FREQ_SAT    = 255;

  typedef enum logic [1:0] {
    OP_MS   = 2'd0,
    OP_DUTY = 2'd1,
    OP_FREQ = 2'd2
  } div_op_e;

  typedef struct packed {
    logic    take_item;
    logic    start_div;
    div_op_e op;
    logic    store_ms;
    logic    cap_duty;
    logic    cap_freq;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic edge_seen;
    logic div_busy;
    logic period_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== hdl/pwmm_div.sv =====
// ----------------------------------------------------------------------------
// PWM meter serial divider
// Restoring divider that retires one quotient bit per cycle. The caller
// preloads the partial remainder and left-aligns the numerator bits to run.
// ----------------------------------------------------------------------------
module pwmm_div #(
  parameter int NW = 35,
  parameter int DW = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DW-1:0]            rem_init_i,
  input  logic [NW-1:0]            num_init_i,
  input  logic [DW-1:0]            den_i,
  input  logic [$clog2(NW+1)-1:0]  steps_i,
  output logic                     busy_o,
  output logic [NW-1:0]            quo_o
);
  localparam int SCW = $clog2(NW+1);

  logic           busy_q, busy_d;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]  rem_q, rem_d;
  logic [NW-1:0]  num_q, num_d;
  logic [NW-1:0]  quo_q, quo_d;
  logic [DW-1:0]  den_q, den_d;
  logic [DW:0]    rem_sh;
  logic [DW:0]    rem_sub;
  logic           ge;

  assign rem_sh  = {rem_q, num_q[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_init_i;
      num_d  = num_init_i;
      quo_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      num_d = {num_q[NW-2:0], 1'b0};
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - SCW'(1);
      if (cnt_q == SCW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/pwmm_datapath.sv =====
// ----------------------------------------------------------------------------
// PWM meter datapath
// Phase tick counter, configuration registers, tick-to-millisecond product,
// stored phase times, the shared serial divider and the output register.
// ----------------------------------------------------------------------------
module pwmm_datapath #(
  parameter int COUNT_WIDTH = pwmm_pkg::DEF_COUNT_WIDTH,
  parameter int MS_WIDTH    = pwmm_pkg::DEF_MS_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pwmm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [pwmm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              pin_level_i,
  input  pwmm_pkg::ctrl_cmd_t               cmd_i,
  output pwmm_pkg::ctrl_sts_t               sts_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [pwmm_pkg::M_TDATA_W-1:0]    m_data_o,
  output logic [pwmm_pkg::M_TUSER_W-1:0]    m_user_o
);
  import pwmm_pkg::*;

  localparam int PROD_W = COUNT_WIDTH + PRESCALE_W;
  localparam int DUTY_N_W = MS_WIDTH + DUTY_STEPS;
  localparam int NW0 = (PROD_W > DUTY_N_W) ? PROD_W : DUTY_N_W;
  localparam int NW  = (NW0 > FREQ_STEPS) ? NW0 : FREQ_STEPS;
  localparam int DW  = (CLOCK_KHZ_W > MS_WIDTH + 1) ? CLOCK_KHZ_W : MS_WIDTH + 1;
  localparam int SCW = $clog2(NW+1);
  localparam int PAD_W = M_TDATA_W - HIGH_MS_W - LOW_MS_W - DUTY_W - FREQ_W;

  logic [PRESCALE_W-1:0]  prescale_q;
  logic [CLOCK_KHZ_W-1:0] clock_khz_q;
  logic [COUNT_WIDTH-1:0] ticks_q;
  logic                   prev_q;
  logic                   from_high_q;
  logic [PROD_W-1:0]      prod_q;
  logic [MS_WIDTH-1:0]    high_q;
  logic [MS_WIDTH-1:0]    low_q;
  logic [MS_WIDTH:0]      period_q;
  logic [DUTY_W-1:0]      duty_q;
  logic [FREQ_W-1:0]      freq_q;
  logic                   m_valid_q;
  logic [HIGH_MS_W-1:0]   out_high_q;
  logic [LOW_MS_W-1:0]    out_low_q;
  logic [DUTY_W-1:0]      out_duty_q;
  logic [FREQ_W-1:0]      out_freq_q;
  logic                   out_zero_q;

  logic                   edge_seen;
  logic [MS_WIDTH-1:0]    ms_sat;
  logic [MS_WIDTH:0]      period_d;
  logic [DUTY_N_W-1:0]    duty_num;
  logic [CLOCK_KHZ_W-1:0] den_khz;
  logic [DW-1:0]          div_rem;
  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic [SCW-1:0]         div_steps;
  logic                   div_busy;
  logic [NW-1:0]          div_quo;
  logic                   period_zero;

  assign edge_seen   = pin_level_i != prev_q;
  assign period_zero = period_q == '0;
  assign den_khz     = (clock_khz_q == '0) ? CLOCK_KHZ_W'(1) : clock_khz_q;
  assign duty_num    = DUTY_N_W'(high_q) * DUTY_N_W'(DUTY_SCALE);
  assign ms_sat      = (|div_quo[NW-1:MS_WIDTH]) ? '1 : div_quo[MS_WIDTH-1:0];
  assign period_d    = from_high_q ? ({1'b0, ms_sat} + {1'b0, low_q})
                                   : ({1'b0, high_q} + {1'b0, ms_sat});

  always_comb begin
    case (cmd_i.op)
      OP_MS: begin
        div_rem   = '0;
        div_num   = NW'(prod_q);
        div_den   = DW'(den_khz);
        div_steps = SCW'(NW);
      end
      OP_DUTY: begin
        div_rem   = DW'(duty_num[DUTY_N_W-1:DUTY_STEPS]);
        div_num   = NW'(duty_num[DUTY_STEPS-1:0]) << (NW - DUTY_STEPS);
        div_den   = DW'(period_q);
        div_steps = SCW'(DUTY_STEPS);
      end
      OP_FREQ: begin
        div_rem   = '0;
        div_num   = NW'(FREQ_NUM) << (NW - FREQ_STEPS);
        div_den   = DW'(period_q);
        div_steps = SCW'(FREQ_STEPS);
      end
      default: begin
        div_rem   = '0;
        div_num   = '0;
        div_den   = DW'(1);
        div_steps = SCW'(1);
      end
    endcase
  end

  pwmm_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .rem_init_i (div_rem),
    .num_init_i (div_num),
    .den_i      (div_den),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q  <= PRESCALE_RST;
      clock_khz_q <= CLOCK_KHZ_RST;
      ticks_q     <= '0;
      prev_q      <= 1'b0;
      from_high_q <= 1'b0;
      high_q      <= '0;
      low_q       <= '0;
      period_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_PRESCALE) begin
          prescale_q <= cfg_data_i[PRESCALE_W-1:0];
        end else if (cfg_addr_i == CFG_CLOCK_KHZ) begin
          clock_khz_q <= cfg_data_i[CLOCK_KHZ_W-1:0];
        end
      end
      if (cmd_i.take_item) begin
        if (edge_seen) begin
          ticks_q     <= COUNT_WIDTH'(1);
          prev_q      <= pin_level_i;
          from_high_q <= prev_q;
        end else if (ticks_q != '1) begin
          ticks_q <= ticks_q + COUNT_WIDTH'(1);
        end
      end
      if (cmd_i.store_ms) begin
        if (from_high_q) begin
          high_q <= ms_sat;
        end else begin
          low_q <= ms_sat;
        end
        period_q <= period_d;
      end
      if (cmd_i.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && edge_seen) begin
      prod_q <= PROD_W'(ticks_q) * PROD_W'(prescale_q);
    end
    if (cmd_i.cap_duty) begin
      duty_q <= div_quo[DUTY_W-1:0];
    end
    if (cmd_i.cap_freq) begin
      freq_q <= (div_quo > NW'(FREQ_SAT)) ? FREQ_W'(FREQ_SAT) : div_quo[FREQ_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_high_q <= HIGH_MS_W'(high_q);
      out_low_q  <= LOW_MS_W'(low_q);
      out_duty_q <= period_zero ? '0 : duty_q;
      out_freq_q <= period_zero ? '0 : freq_q;
      out_zero_q <= period_zero;
    end
  end

  assign sts_o.edge_seen   = edge_seen;
  assign sts_o.div_busy    = div_busy;
  assign sts_o.period_zero = period_zero;
  assign sts_o.out_free    = !m_valid_q || m_ready_i;

  assign m_valid_o = m_valid_q;
  assign m_data_o  = {PAD_W'(0), out_freq_q, out_duty_q, out_low_q, out_high_q};
  assign m_user_o  = out_zero_q;

endmodule

// ===== hdl/pwmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// PWM meter controller
// Sequences one edge item through conversion, store, nonzero-period duty and
// frequency divisions and output load; plain ticks finish in the accept cycle.
// ----------------------------------------------------------------------------
module pwmm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pwmm_pkg::ctrl_sts_t sts_i,
  output pwmm_pkg::ctrl_cmd_t cmd_o
);
  import pwmm_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_MS_START   = 9'b000000010,
    ST_MS_WAIT    = 9'b000000100,
    ST_STORE      = 9'b000001000,
    ST_DUTY_START = 9'b000010000,
    ST_DUTY_WAIT  = 9'b000100000,
    ST_FREQ_START = 9'b001000000,
    ST_FREQ_WAIT  = 9'b010000000,
    ST_OUT        = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.op        = OP_MS;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take_item = in_valid_i;
        if (in_valid_i && sts_i.edge_seen) begin
          state_d = ST_MS_START;
        end
      end
      ST_MS_START: begin
        cmd_o.start_div = 1'b1;
        state_d         = ST_MS_WAIT;
      end
      ST_MS_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store_ms = 1'b1;
        state_d        = ST_DUTY_START;
      end
      ST_DUTY_START: begin
        cmd_o.op = OP_DUTY;
        if (sts_i.period_zero) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DUTY_WAIT;
        end
      end
      ST_DUTY_WAIT: begin
        cmd_o.op = OP_DUTY;
        if (!sts_i.div_busy) begin
          cmd_o.cap_duty = 1'b1;
          state_d        = ST_FREQ_START;
        end
      end
      ST_FREQ_START: begin
        cmd_o.op        = OP_FREQ;
        cmd_o.start_div = 1'b1;
        state_d         = ST_FREQ_WAIT;
      end
      ST_FREQ_WAIT: begin
        cmd_o.op = OP_FREQ;
        if (!sts_i.div_busy) begin
          cmd_o.cap_freq = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

// ===== hdl/pwm_duty_frequency_meter_core.sv =====
// ----------------------------------------------------------------------------
// PWM duty and frequency meter
//
//   channel  direction  carries
//   s_axis   in         one timer tick item with the sampled pin level
//   m_axis   out        high ms, low ms, duty, frequency, zero period flag
//   cfg      in         prescale factor and clock kHz, written without wait
//
// A tick without a level change finishes in the cycle it is accepted. A tick
// with a level change runs the serial divider, which retires one quotient bit
// per cycle, for the millisecond conversion and then, unless the period is
// zero, for duty and frequency.
// Reset is asynchronous and active low and leaves no result pending.
// A result waits in the output register; the next item is still taken, and
// only a following edge item stalls until that result has been taken.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter_core #(
  parameter int COUNT_WIDTH = pwmm_pkg::DEF_COUNT_WIDTH,
  parameter int MS_WIDTH    = pwmm_pkg::DEF_MS_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pwmm_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [pwmm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pin_level in bit 0, zeros above
  input  logic [pwmm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // high_ms [19:0], low_ms [39:20], duty_pct [46:40], freq_hz [54:47], zero fill [55]
  output logic [pwmm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // zero_period
  output logic [pwmm_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
  import pwmm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pwmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pwmm_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .MS_WIDTH    (MS_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .pin_level_i (s_axis_tdata[0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

// ===== verif/pwm_meter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM meter result checker
// Watches the configuration port and both streams of the meter. Each tick
// that is taken updates a private model of the phase counter and of the
// stored high and low times. Each level change queues the measurement it
// should produce. Every result that leaves the block is compared field by
// field with the oldest queued measurement, and each mismatch is counted.
// ----------------------------------------------------------------------------
module pwm_meter_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pwmm_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [pwmm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // pin_level in bit 0, zeros above
  input  logic [pwmm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // high_ms, low_ms, duty_pct, freq_hz, zero fill
  input  logic [pwmm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // zero_period
  input  logic [pwmm_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  output int                               fail_count_o,
  output int                               pending_o
);
  import pwmm_pkg::*;

  localparam int FIELDS_W = HIGH_MS_W + LOW_MS_W + DUTY_W + FREQ_W;

  typedef struct {
    logic [HIGH_MS_W-1:0] high_ms;
    logic [LOW_MS_W-1:0]  low_ms;
    logic [DUTY_W-1:0]    duty_pct;
    logic [FREQ_W-1:0]    freq_hz;
    logic                 zero_period;
  } meas_t;

  logic [DEF_COUNT_WIDTH-1:0] tick_count;
  logic                       last_level;
  logic [DEF_MS_WIDTH-1:0]    high_time;
  logic [DEF_MS_WIDTH-1:0]    low_time;
  logic [PRESCALE_W-1:0]      prescale;
  logic [CLOCK_KHZ_W-1:0]     clock_khz;
  meas_t                      meas_q[$];
  int                         fail_cnt = 0;

  assign fail_count_o = fail_cnt;

  function automatic logic [DEF_MS_WIDTH-1:0] ticks_to_ms(
    input logic [DEF_COUNT_WIDTH-1:0] ticks
  );
    logic [63:0] ms;
    ms = 64'(ticks) * 64'(prescale);
    ms = ms / ((clock_khz == '0) ? 64'd1 : 64'(clock_khz));
    if (ms > 64'({DEF_MS_WIDTH{1'b1}})) begin
      return '1;
    end
    return ms[DEF_MS_WIDTH-1:0];
  endfunction

  function automatic void predict_tick(input logic level);
    meas_t       m;
    int unsigned period;
    if (level == last_level) begin
      if (tick_count != '1) begin
        tick_count = tick_count + 1'b1;
      end
    end else begin
      if (last_level) begin
        high_time = ticks_to_ms(tick_count);
      end else begin
        low_time = ticks_to_ms(tick_count);
      end
      tick_count = DEF_COUNT_WIDTH'(1);
      last_level = level;
      period = int'(high_time) + int'(low_time);
      m.high_ms = high_time;
      m.low_ms = low_time;
      m.duty_pct = '0;
      m.freq_hz = '0;
      m.zero_period = (period == 0);
      if (period != 0) begin
        m.duty_pct = DUTY_W'((DUTY_SCALE * int'(high_time)) / period);
        m.freq_hz = (FREQ_NUM / period > FREQ_SAT) ? FREQ_W'(FREQ_SAT)
                                                   : FREQ_W'(FREQ_NUM / period);
      end
      meas_q.push_back(m);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("%0t: meter mismatch on %s: got %0d, expected %0d",
             $time, what, got, exp);
    fail_cnt++;
  endtask

  task automatic check_result();
    meas_t got;
    meas_t exp;
    got.high_ms = m_axis_tdata[HIGH_MS_W-1:0];
    got.low_ms = m_axis_tdata[HIGH_MS_W +: LOW_MS_W];
    got.duty_pct = m_axis_tdata[HIGH_MS_W + LOW_MS_W +: DUTY_W];
    got.freq_hz = m_axis_tdata[HIGH_MS_W + LOW_MS_W + DUTY_W +: FREQ_W];
    got.zero_period = m_axis_tuser[0];
    if (m_axis_tdata[M_TDATA_W-1:FIELDS_W] !== '0) begin
      report_mismatch("tdata fill bits", int'(m_axis_tdata[M_TDATA_W-1:FIELDS_W]), 0);
    end
    if (meas_q.size() == 0) begin
      report_mismatch("result with nothing expected", int'(got.high_ms), 0);
    end else begin
      exp = meas_q.pop_front();
      if (got.high_ms !== exp.high_ms) begin
        report_mismatch("high_ms", int'(got.high_ms), int'(exp.high_ms));
      end
      if (got.low_ms !== exp.low_ms) begin
        report_mismatch("low_ms", int'(got.low_ms), int'(exp.low_ms));
      end
      if (got.duty_pct !== exp.duty_pct) begin
        report_mismatch("duty_pct", int'(got.duty_pct), int'(exp.duty_pct));
      end
      if (got.freq_hz !== exp.freq_hz) begin
        report_mismatch("freq_hz", int'(got.freq_hz), int'(exp.freq_hz));
      end
      if (got.zero_period !== exp.zero_period) begin
        report_mismatch("zero_period", int'(got.zero_period), int'(exp.zero_period));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count = '0;
      last_level = 1'b0;
      high_time = '0;
      low_time = '0;
      prescale = PRESCALE_RST;
      clock_khz = CLOCK_KHZ_RST;
      meas_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_PRESCALE) begin
          prescale = cfg_data_i[PRESCALE_W-1:0];
        end else if (cfg_addr_i == CFG_CLOCK_KHZ) begin
          clock_khz = cfg_data_i[CLOCK_KHZ_W-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(s_axis_tdata[0]);
      end
      pending_o <= meas_q.size();
    end
  end

endmodule

// ===== verif/pwm_duty_frequency_meter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM duty and frequency meter testbench
// Feeds the meter with runs of pin levels, first a few hand-picked patterns
// for zero periods, saturated frequency and duty at both ends, then random
// runs under several prescale and clock settings and with gaps on both
// streams. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter_core_tb;
  import pwmm_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 100;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = CFG_PRESCALE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;

  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending;
  logic cur_level = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pwm_duty_frequency_meter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pwm_meter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic level);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= S_TDATA_W'(level);
    cur_level = level;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_run(input logic level, input int len);
    repeat (len) send_tick(level);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [PRESCALE_W-1:0] pre,
                             input logic [CLOCK_KHZ_W-1:0] khz);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_PRESCALE;
    cfg_data_i <= CFG_DATA_W'(pre);
    @(posedge clk_i);
    cfg_addr_i <= CFG_CLOCK_KHZ;
    cfg_data_i <= CFG_DATA_W'(khz);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly short phases so that edges are frequent, with some longer ones.
  task automatic random_runs(input int n_ticks);
    int sent;
    int len;
    sent = 0;
    while (sent < n_ticks) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      send_run(~cur_level, len);
      sent += len;
    end
  endtask

  initial begin
    int rand_pre;
    int rand_khz;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: short phases round to zero ms, so the period is zero.
    send_run(1'b0, 2);
    send_tick(1'b1);
    send_tick(1'b0);

    // One tick per millisecond: the shortest period saturates the frequency.
    reconfigure(11'd1, 16'd1);
    send_run(1'b1, 3);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // Half a millisecond per tick: single ticks round to zero, giving
    // duty at both ends and a zero period again.
    reconfigure(11'd1, 16'd2);
    send_tick(1'b1);
    send_run(1'b0, 4);
    send_run(1'b1, 4);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    reconfigure(11'd1, 16'd1);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    random_runs(100);

    reconfigure(11'd1024, 16'd65535);
    src_idle_pct = 66;
    sink_stall_pct = 0;
    random_runs(50);
    wait_results();
    random_runs(50);

    rand_pre = $urandom_range(1, 1024);
    rand_khz = $urandom_range(1, rand_pre);
    reconfigure(PRESCALE_W'(rand_pre), CLOCK_KHZ_W'(rand_khz));
    src_idle_pct = 0;
    sink_stall_pct = 66;
    random_runs(100);

    reconfigure(11'd1024, 16'd1);
    src_idle_pct = 22;
    sink_stall_pct = 22;
    random_runs(100);

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
